[rtl/ofpsm_pkg.sv]
`timescale 1ns / 1ps
package ofpsm_pkg;

  // Pool size default and fixed field widths
  localparam int SLOTS_DEF = 64;
  localparam int NODE_W    = 48;
  localparam int LEN_W     = 12;
  localparam int SEQ_IN_W  = 32;
  localparam int SEQ_W     = 31;
  localparam int SLOT_OUT_W = 6;
  localparam int ERR_W     = 32;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 1;

  // Header word bytes stripped from the length
  localparam logic [LEN_W-1:0] HDR_BYTES   = LEN_W'(4);
  localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(546);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_NODE   = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED    = 3'd0,
    ST_OWN       = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NEG_SEQ   = 3'd4,
    ST_DELIVERED = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RX,
    S_RX_WR,
    S_SCAN,
    S_FETCH_END,
    S_DONE
  } state_t;

endpackage

[rtl/ofpsm_if.sv]
`timescale 1ns / 1ps
interface ofpsm_in_if import ofpsm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [NODE_W-1:0]          source_node;
  logic [LEN_W-1:0]           length;
  logic signed [SEQ_IN_W-1:0] sequence_req;

  modport source (output valid, func, source_node, length, sequence_req, input ready);
  modport sink   (input valid, func, source_node, length, sequence_req, output ready);
endinterface

interface ofpsm_out_if import ofpsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [LEN_W-1:0]      payload_size;
  logic [SEQ_W-1:0]      seq_out;
  logic [ERR_W-1:0]      error_total;

  modport source (output valid, status, slot, payload_size, seq_out, error_total,
                  input ready);
  modport sink   (input valid, status, slot, payload_size, seq_out, error_total,
                  output ready);
endinterface

interface ofpsm_cfg_if import ofpsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NODE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ofpsm_free_stack.sv]
`timescale 1ns / 1ps
module ofpsm_free_stack #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_r;

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/oldest_first_packet_slot_manager.sv]
// Receive: the request is checked, a stored packet is written into its slot, then the
// result is loaded into the output register; a rejected one skips the slot write. Fetch:
// a scan of the slot memory through one shared comparator, one slot per cycle.
// One request at a time: ready returns the cycle after the result is loaded; a finished
// result may wait in the output register.
// Reset (rst_n low, synchronous) starts a free stack fill; requests wait.
`timescale 1ns / 1ps
module oldest_first_packet_slot_manager import ofpsm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ofpsm_cfg_if.sink      cfg_wr,
  ofpsm_in_if.sink       in_req,
  ofpsm_out_if.source    out_res
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ENT_W  = LEN_W + SEQ_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

  state_t state_r, state_nxt;

  logic [NODE_W-1:0] own_node_r;
  logic [LEN_W-1:0]  max_length_r;

  logic              own_hit_r;
  logic [LEN_W-1:0]  len_r;
  logic [SEQ_IN_W-1:0] seq_r;

  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOTS-1:0]  occ_r, occ_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;

  logic              pv_r, pv_nxt;
  logic [SLOT_W-1:0] pidx_r, pidx_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic [SEQ_W-1:0]  best_seq_r, best_seq_nxt;
  logic [LEN_W-1:0]  best_size_r, best_size_nxt;

  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [LEN_W-1:0]  res_size_r, res_size_nxt;
  logic [SEQ_W-1:0]  res_seq_r, res_seq_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_stat_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [LEN_W-1:0]      out_size_r;
  logic [SEQ_W-1:0]      out_seq_r;
  logic [ERR_W-1:0]      out_err_r;
  logic                  out_load;

  logic              in_acc;
  logic              stk_we;
  logic [SLOT_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  logic [ENT_W-1:0]  slot_mem [SLOTS];
  logic [ENT_W-1:0]  mem_q_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_raddr;
  logic [LEN_W-1:0]  rx_size;
  logic [SEQ_W-1:0]  q_seq;
  logic [LEN_W-1:0]  q_size;
  logic              cmp_lt;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  assign q_seq  = mem_q_r[SEQ_W-1:0];
  assign q_size = mem_q_r[ENT_W-1:SEQ_W];
  // Shared comparator of the scan
  assign cmp_lt = (q_seq < best_seq_r);

  assign rx_size   = (len_r >= HDR_BYTES) ? (len_r - HDR_BYTES) : '0;
  assign stk_raddr = used_r[SLOT_W-1:0];
  assign mem_raddr = (cnt_r < CNT_FULL) ? cnt_r[SLOT_W-1:0] : '0;

  ofpsm_free_stack #(
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_free_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Slot memory: payload size and sequence, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[stk_rdata] <= {rx_size, seq_r[SEQ_W-1:0]};
    end
    mem_q_r <= slot_mem[mem_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r   <= '0;
      max_length_r <= MAX_LEN_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        CFG_OWN_NODE:   own_node_r   <= cfg_wr.data;
        CFG_MAX_LENGTH: max_length_r <= cfg_wr.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      own_hit_r <= (in_req.source_node == own_node_r);
      len_r     <= in_req.length;
      seq_r     <= in_req.sequence_req;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      used_r      <= '0;
      cnt_r       <= '0;
      occ_r       <= '0;
      err_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      err_r       <= err_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_seq_r  <= best_seq_nxt;
    best_size_r <= best_size_nxt;
    res_stat_r  <= res_stat_nxt;
    res_slot_r  <= res_slot_nxt;
    res_size_r  <= res_size_nxt;
    res_seq_r   <= res_seq_nxt;
    if (out_load) begin
      out_stat_r <= res_stat_r;
      out_slot_r <= SLOT_OUT_W'(res_slot_r);
      out_size_r <= res_size_r;
      out_seq_r  <= res_seq_r;
      out_err_r  <= err_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    occ_nxt       = occ_r;
    err_nxt       = err_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_seq_nxt  = best_seq_r;
    best_size_nxt = best_size_r;
    res_stat_nxt  = res_stat_r;
    res_slot_nxt  = res_slot_r;
    res_size_nxt  = res_size_r;
    res_seq_nxt   = res_seq_r;
    stk_we        = 1'b0;
    stk_waddr     = cnt_r[SLOT_W-1:0];
    stk_wdata     = cnt_r[SLOT_W-1:0];
    mem_we        = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      // Fill the free stack with identity ids
      S_INIT: begin
        stk_we = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = in_req.func ? S_SCAN : S_RX;
        end
      end
      // Check the receive request; the stack read runs meanwhile
      S_RX: begin
        res_slot_nxt = '0;
        res_size_nxt = '0;
        res_seq_nxt  = '0;
        state_nxt    = S_DONE;
        if (own_hit_r) begin
          res_stat_nxt = ST_OWN;
        end else if (len_r == '0 || len_r > max_length_r) begin
          res_stat_nxt = ST_BAD_LEN;
          err_nxt      = err_r + ERR_W'(1);
        end else if (used_r >= CNT_FULL) begin
          res_stat_nxt = ST_FULL;
          err_nxt      = err_r + ERR_W'(1);
        end else if (seq_r[SEQ_IN_W-1]) begin
          res_stat_nxt = ST_NEG_SEQ;
          err_nxt      = err_r + ERR_W'(1);
        end else begin
          res_stat_nxt = ST_STORED;
          state_nxt    = S_RX_WR;
        end
      end
      // Store into the popped slot
      S_RX_WR: begin
        mem_we             = 1'b1;
        occ_nxt[stk_rdata] = 1'b1;
        used_nxt           = used_r + CNT_W'(1);
        res_slot_nxt       = stk_rdata;
        res_size_nxt       = rx_size;
        state_nxt          = S_DONE;
      end
      // Issue one read per cycle, compare the previous one
      S_SCAN: begin
        if (cnt_r != CNT_FULL) begin
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[SLOT_W-1:0];
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else if (!pv_r) begin
          state_nxt = S_FETCH_END;
        end
        if (pv_r && occ_r[pidx_r] && (!found_r || cmp_lt)) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = pidx_r;
          best_seq_nxt  = q_seq;
          best_size_nxt = q_size;
        end
      end
      // Free the winner and push its id back
      S_FETCH_END: begin
        state_nxt = S_DONE;
        if (found_r) begin
          occ_nxt[best_idx_r] = 1'b0;
          res_stat_nxt = ST_DELIVERED;
          res_slot_nxt = best_idx_r;
          res_size_nxt = best_size_r;
          res_seq_nxt  = best_seq_r;
          if (used_r != '0) begin
            used_nxt  = used_r - CNT_W'(1);
            stk_we    = 1'b1;
            stk_waddr = used_nxt[SLOT_W-1:0];
            stk_wdata = best_idx_r;
          end
        end else begin
          res_stat_nxt = ST_EMPTY;
          res_slot_nxt = '0;
          res_size_nxt = '0;
          res_seq_nxt  = '0;
        end
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_res.ready);
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_stat_r;
  assign out_res.slot         = out_slot_r;
  assign out_res.payload_size = out_size_r;
  assign out_res.seq_out      = out_seq_r;
  assign out_res.error_total  = out_err_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_FULL)
    else $error("used count above pool size");

  a_occ_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(occ_r) == int'(used_r)))
    else $error("occupied slots disagree with used count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("sequencer idle right after a request");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");
`endif

endmodule

[tb/ofpsm_slot_checker.sv]
`timescale 1ns / 1ps
module ofpsm_slot_checker import ofpsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ofpsm_cfg_if        cfg_mon,
  ofpsm_in_if         req_mon,
  ofpsm_out_if        res_mon,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  localparam int POOL         = SLOTS_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [LEN_W-1:0]      payload;
    logic [SEQ_W-1:0]      seq_no;
    logic [ERR_W-1:0]      rejects;
  } slot_result_t;

  // Shadow copy of the pool and the two registers
  logic [SLOT_OUT_W-1:0] free_ids [POOL];
  int unsigned           used_slots;
  logic [SEQ_IN_W-1:0]   slot_seq [POOL];
  logic [LEN_W-1:0]      slot_payload [POOL];
  logic [ERR_W-1:0]      reject_count;
  logic [NODE_W-1:0]     own_node;
  logic [LEN_W-1:0]      max_length;
  slot_result_t          pending_results [$];
  int unsigned           fail_total = 0;

  assign mismatch_count = fail_total;

  task automatic clear_pool();
    for (int i = 0; i < POOL; i++) begin
      free_ids[i]     = SLOT_OUT_W'(i);
      slot_seq[i]     = '1;
      slot_payload[i] = '0;
    end
    used_slots   = 0;
    reject_count = '0;
    own_node     = '0;
    max_length   = MAX_LEN_RST;
  endtask

  // Apply one request to the shadow pool and return the result it should give
  function automatic slot_result_t manage_slot_request(
    input logic                fetch,
    input logic [NODE_W-1:0]   src,
    input logic [LEN_W-1:0]    len,
    input logic [SEQ_IN_W-1:0] seq
  );
    slot_result_t        r;
    int unsigned         id;
    int unsigned         best;
    logic                found;
    logic [SEQ_IN_W-1:0] best_seq;
    logic [LEN_W-1:0]    size;
    r        = '0;
    found    = 1'b0;
    best     = 0;
    best_seq = '0;
    if (!fetch) begin
      if (src == own_node) begin
        r.status = ST_OWN;
      end else if (len == '0 || len > max_length) begin
        reject_count++;
        r.status = ST_BAD_LEN;
      end else if (used_slots >= POOL) begin
        reject_count++;
        r.status = ST_FULL;
      end else if (seq[SEQ_IN_W-1]) begin
        reject_count++;
        r.status = ST_NEG_SEQ;
      end else begin
        // pop a slot id and record the packet in it
        id = int'(free_ids[used_slots]) % POOL;
        used_slots++;
        size = (len >= HDR_BYTES) ? len - HDR_BYTES : '0;
        slot_payload[id] = size;
        slot_seq[id]     = seq;
        r.status  = ST_STORED;
        r.slot    = SLOT_OUT_W'(id);
        r.payload = size;
      end
    end else begin
      // lowest sequence wins, lowest index on a tie
      for (int i = 0; i < POOL; i++) begin
        if (!slot_seq[i][SEQ_IN_W-1] && (!found || slot_seq[i] < best_seq)) begin
          found    = 1'b1;
          best     = i;
          best_seq = slot_seq[i];
        end
      end
      if (!found) begin
        r.status = ST_EMPTY;
      end else begin
        slot_seq[best] = '1;
        if (used_slots > 0) begin
          used_slots--;
          free_ids[used_slots] = SLOT_OUT_W'(best);
        end
        r.status  = ST_DELIVERED;
        r.slot    = SLOT_OUT_W'(best);
        r.payload = slot_payload[best];
        r.seq_no  = best_seq[SEQ_W-1:0];
      end
    end
    r.rejects = reject_count;
    return r;
  endfunction

  always @(posedge clk) begin : track
    slot_result_t want;
    if (!rst_n) begin
      clear_pool();
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // follow register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_OWN_NODE:   own_node   = cfg_mon.data;
          CFG_MAX_LENGTH: max_length = cfg_mon.data[LEN_W-1:0];
          default: ;
        endcase
      end
      // compare each delivered result with the oldest prediction
      if (res_mon.valid && res_mon.ready) begin
        if (pending_results.size() == 0) begin
          if (fail_total < REPORT_LIMIT) begin
            $display("%0t: result with no request waiting: status %0d slot %0d",
                     $time, res_mon.status, res_mon.slot);
          end
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          if (res_mon.status !== want.status || res_mon.slot !== want.slot ||
              res_mon.payload_size !== want.payload || res_mon.seq_out !== want.seq_no ||
              res_mon.error_total !== want.rejects) begin
            if (fail_total < REPORT_LIMIT) begin
              $display("%0t: got status %0d slot %0d size %0d seq %0d errors %0d",
                       $time, res_mon.status, res_mon.slot, res_mon.payload_size,
                       res_mon.seq_out, res_mon.error_total);
              $display("%0t: want status %0d slot %0d size %0d seq %0d errors %0d",
                       $time, want.status, want.slot, want.payload, want.seq_no,
                       want.rejects);
            end
            fail_total++;
          end
        end
      end
      // predict each accepted request
      if (req_mon.valid && req_mon.ready) begin
        pending_results.push_back(manage_slot_request(req_mon.func, req_mon.source_node,
                                                      req_mon.length, req_mon.sequence_req));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ofpsm_pkg::*;

  localparam int          RESET_CYCLES  = 12;
  localparam int          RANDOM_ITEMS  = 1050;
  localparam int          SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam logic        FN_RECEIVE    = 1'b0;
  localparam logic        FN_FETCH      = 1'b1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ofpsm_cfg_if cfg_ch ();
  ofpsm_in_if  req_ch ();
  ofpsm_out_if res_ch ();

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned cycle_count = 0;

  // Sender state and the register values now in force
  int                burst_left = 0;
  bit                gaps_off   = 1'b0;
  logic [NODE_W-1:0] cur_node   = '0;
  logic [LEN_W-1:0]  cur_limit  = MAX_LEN_RST;

  oldest_first_packet_slot_manager u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_ch),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  ofpsm_slot_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_mon        (cfg_ch),
    .req_mon        (req_ch),
    .res_mon        (res_ch),
    .mismatch_count (mismatches),
    .outstanding    (awaiting)
  );

  always #10 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: stall in modes that are picked at random
  initial begin : result_stall
    int hold_left;
    int mode;
    hold_left = 0;
    mode      = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0) begin
        mode      = $urandom_range(0, 2);
        hold_left = $urandom_range(50, 400);
      end
      hold_left--;
      case (mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        default: res_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Send one request; a new burst may open with an idle gap
  task automatic push_request(input logic fn, input logic [NODE_W-1:0] src,
                              input logic [LEN_W-1:0] len, input logic [SEQ_IN_W-1:0] seq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = gaps_off ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= fn;
    req_ch.source_node  <= src;
    req_ch.length       <= len;
    req_ch.sequence_req <= seq;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_for_deliveries();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic set_config(input bit wr_node, input logic [NODE_W-1:0] node,
                            input bit wr_len, input logic [LEN_W-1:0] limit);
    if (wr_node) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_OWN_NODE;
      cfg_ch.data  <= node;
      do @(posedge clk); while (!cfg_ch.ready);
      cur_node = node;
    end
    if (wr_len) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_MAX_LENGTH;
      cfg_ch.data  <= NODE_W'(limit);
      do @(posedge clk); while (!cfg_ch.ready);
      cur_limit = limit;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random request biased toward lengths at the limits and tied sequence numbers
  task automatic send_random(input int rx_pct, inout int counted);
    logic              fn;
    logic [NODE_W-1:0] src;
    logic [LEN_W-1:0]  len;
    logic [SEQ_IN_W-1:0] seq;
    int                pick;
    fn   = ($urandom_range(0, 99) < rx_pct) ? FN_RECEIVE : FN_FETCH;
    pick = $urandom_range(0, 99);
    if (pick < 6)       src = cur_node;
    else if (pick < 10) src = cur_node ^ (NODE_W'(1) << $urandom_range(0, NODE_W - 1));
    else                src = NODE_W'({$urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    if (pick < 4)       len = '0;
    else if (pick < 10) len = LEN_W'($urandom_range(1, 3));
    else if (pick < 14) len = HDR_BYTES;
    else if (pick < 20) len = cur_limit;
    else if (pick < 26) len = LEN_W'(cur_limit + 1);
    else if (pick < 34) len = LEN_W'($urandom());
    else                len = LEN_W'($urandom_range(1, int'(cur_limit)));
    pick = $urandom_range(0, 99);
    if (pick < 10)      seq = 32'h8000_0000 | $urandom();
    else if (pick < 40) seq = SEQ_IN_W'($urandom_range(0, 15));
    else if (pick < 45) seq = 32'h7FFF_FFFF;
    else if (pick < 48) seq = '0;
    else                seq = {1'b0, 31'($urandom())};
    if (fn == FN_FETCH || src != cur_node) counted++;
    push_request(fn, src, len, seq);
  endtask

  initial begin : stimulus
    int counted;
    int phase;
    int rx_pct;
    int phase_len;
    logic [NODE_W-1:0] node;
    logic [LEN_W-1:0]  limit;
    counted = 0;
    phase   = 0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_OWN_NODE;
    cfg_ch.data         <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= FN_RECEIVE;
    req_ch.source_node  <= '0;
    req_ch.length       <= '0;
    req_ch.sequence_req <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, rejections, short packets, ties, extremes
    push_request(FN_FETCH,   '0, '0, '0);
    push_request(FN_RECEIVE, 48'h0, 12'd0, 32'd7);
    push_request(FN_RECEIVE, 48'h1, 12'd0, 32'd7);
    push_request(FN_RECEIVE, 48'h2, LEN_W'(MAX_LEN_RST + 1), 32'd7);
    push_request(FN_RECEIVE, 48'h3, 12'hFFF, 32'd7);
    push_request(FN_RECEIVE, 48'h8000_0000_0000, 12'd1, 32'd5);
    push_request(FN_RECEIVE, 48'h5555_5555_5555, 12'd3, 32'd5);
    push_request(FN_RECEIVE, 48'hAAAA_AAAA_AAAA, HDR_BYTES, 32'd0);
    push_request(FN_RECEIVE, 48'h0000_FFFF_0000, MAX_LEN_RST, 32'h7FFF_FFFF);
    push_request(FN_RECEIVE, 48'h1234_5678_9ABC, 12'd100, 32'h8000_0000);
    push_request(FN_RECEIVE, 48'h1234_5678_9ABD, 12'd100, 32'hFFFF_FFFF);
    push_request(FN_RECEIVE, 48'hFFFF_FFFF_FFFF, 12'd100, 32'd5);
    repeat (6) push_request(FN_FETCH, '1, '1, '1);

    // Random phases: fill, drain or mixed, each under its own register setting
    while (counted < RANDOM_ITEMS) begin
      wait_for_deliveries();
      case (phase % 3)
        0:       node = '1;
        1:       node = NODE_W'({$urandom(), $urandom()});
        default: node = '0;
      endcase
      case (phase % 5)
        0:       limit = 12'hFFF;
        1:       limit = 12'd1;
        2:       limit = MAX_LEN_RST;
        3:       limit = LEN_W'($urandom_range(5, 4095));
        default: limit = HDR_BYTES;
      endcase
      set_config(phase == 0 || $urandom_range(0, 1), node,
                 phase == 0 || $urandom_range(0, 1), limit);
      case ($urandom_range(0, 2))
        0: begin
          rx_pct    = 95;
          phase_len = $urandom_range(60, 140);
        end
        1: begin
          rx_pct    = 15;
          phase_len = $urandom_range(20, 80);
        end
        default: begin
          rx_pct    = 55;
          phase_len = $urandom_range(20, 90);
        end
      endcase
      gaps_off = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_random(rx_pct, counted);
      phase++;
    end

    wait_for_deliveries();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
